>>> hw/rtl/vac_pkg.sv
// Package: widths, payload and pipeline types for the vector angle cosine block.
`default_nettype none
package vac_pkg;

    localparam int COORD_BITS      = 9;
    localparam int DEPTH_FRAC_BITS = 13;
    localparam int COS_FRAC_BITS   = 14;

    localparam int DEPTH_BITS = DEPTH_FRAC_BITS + 3;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int ZDIFF_W    = DEPTH_BITS + 1;
    localparam int XY_PROD_W  = 2 * DIFF_W;
    localparam int Z_PROD_W   = 2 * ZDIFF_W;

    // magnitude of dot and squared lengths, signed sum one bit wider
    localparam int MAG_W  = 2 * COORD_BITS + 2 * DEPTH_FRAC_BITS + 2;
    localparam int SUM_W  = MAG_W + 1;
    localparam int HALF_LO = (MAG_W + 1) / 2;
    localparam int HALF_HI = MAG_W - HALF_LO;
    localparam int PROD_W = 2 * MAG_W;

    // root digits: t reaches 2^(COS_FRAC_BITS+1)
    localparam int COS_W = COS_FRAC_BITS + 2;
    localparam int TB    = COS_FRAC_BITS + 2;
    localparam int WW    = PROD_W + 2 * TB;

    localparam logic [TB-1:0] ONE = TB'(1) << COS_FRAC_BITS;

    typedef struct packed {
        logic                  mode;
        logic [COORD_BITS-1:0] p0_x;
        logic [COORD_BITS-1:0] p0_y;
        logic [DEPTH_BITS-1:0] p0_z;
        logic [COORD_BITS-1:0] p1_x;
        logic [COORD_BITS-1:0] p1_y;
        logic [DEPTH_BITS-1:0] p1_z;
        logic [COORD_BITS-1:0] p2_x;
        logic [COORD_BITS-1:0] p2_y;
        logic [DEPTH_BITS-1:0] p2_z;
    } vac_pts_t;

    // state carried along the root cells
    typedef struct packed {
        logic [WW-1:0] rem;
        logic [WW-1:0] psh;
        logic [WW-1:0] lsh;
        logic [TB-1:0] t;
        logic          neg;
        logic          degen;
    } vac_root_t;

endpackage
`default_nettype wire

>>> hw/rtl/vac_if.sv
// Interfaces: point triple input channel and cosine result channel.
`default_nettype none
interface vac_pts_if
    import vac_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] p0_x;
    logic [COORD_BITS-1:0] p0_y;
    logic [DEPTH_BITS-1:0] p0_z;
    logic [COORD_BITS-1:0] p1_x;
    logic [COORD_BITS-1:0] p1_y;
    logic [DEPTH_BITS-1:0] p1_z;
    logic [COORD_BITS-1:0] p2_x;
    logic [COORD_BITS-1:0] p2_y;
    logic [DEPTH_BITS-1:0] p2_z;

    modport source (
        output valid, mode, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
        input  ready
    );
    modport sink (
        input  valid, mode, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
        output ready
    );
endinterface

interface vac_res_if
    import vac_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [COS_W-1:0] cosine;
    logic                    degenerate;

    modport source (output valid, cosine, degenerate, input ready);
    modport sink (input valid, cosine, degenerate, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/vac_front.sv
// Front pipeline: differences, dot and squared lengths, wide products, root setup.
`default_nettype none
module vac_front
    import vac_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire vac_pts_t  in_pts,
    output logic           in_ready,
    output logic           out_valid,
    output vac_root_t      out_root,
    input  wire logic      out_ready
);

    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic adv_a, adv_b, adv_c, adv_d;

    // stage A: coordinate products
    logic signed [XY_PROD_W-1:0] ab_x_reg, ab_y_reg, aa_x_reg, aa_y_reg, bb_x_reg, bb_y_reg;
    logic signed [Z_PROD_W-1:0]  ab_z_reg, aa_z_reg, bb_z_reg;
    logic                        spatial_a_reg;

    // stage B: magnitudes
    logic [MAG_W-1:0] mag_reg, na_reg, nb_reg;
    logic             neg_b_reg, degen_b_reg;

    // stage C: partial products
    logic [2*HALF_HI-1:0]       mm_hh_reg, nn_hh_reg;
    logic [HALF_HI+HALF_LO-1:0] mm_hl_reg, nn_hl_reg, nn_lh_reg;
    logic [2*HALF_LO-1:0]       mm_ll_reg, nn_ll_reg;
    logic                       neg_c_reg, degen_c_reg;

    vac_root_t root_reg;

    // stall chain, bubbles collapse
    assign adv_d    = !vd_reg || out_ready;
    assign adv_c    = !vc_reg || adv_d;
    assign adv_b    = !vb_reg || adv_c;
    assign adv_a    = !va_reg || adv_b;
    assign in_ready = adv_a;
    assign out_valid = vd_reg;
    assign out_root  = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (adv_a) va_reg <= in_valid;
            if (adv_b) vb_reg <= va_reg;
            if (adv_c) vc_reg <= vb_reg;
            if (adv_d) vd_reg <= vc_reg;
        end
    end

    // stage A logic
    logic signed [DIFF_W-1:0]  ax, ay, bx, by;
    logic signed [ZDIFF_W-1:0] az, bz;

    always_comb
    begin
        ax = $signed({1'b0, in_pts.p1_x}) - $signed({1'b0, in_pts.p0_x});
        ay = $signed({1'b0, in_pts.p1_y}) - $signed({1'b0, in_pts.p0_y});
        bx = $signed({1'b0, in_pts.p2_x}) - $signed({1'b0, in_pts.p0_x});
        by = $signed({1'b0, in_pts.p2_y}) - $signed({1'b0, in_pts.p0_y});
        az = $signed({1'b0, in_pts.p1_z}) - $signed({1'b0, in_pts.p0_z});
        bz = $signed({1'b0, in_pts.p2_z}) - $signed({1'b0, in_pts.p0_z});
    end

    always_ff @(posedge clk)
    begin
        if (adv_a && in_valid)
        begin
            ab_x_reg      <= ax * bx;
            ab_y_reg      <= ay * by;
            aa_x_reg      <= ax * ax;
            aa_y_reg      <= ay * ay;
            bb_x_reg      <= bx * bx;
            bb_y_reg      <= by * by;
            ab_z_reg      <= az * bz;
            aa_z_reg      <= az * az;
            bb_z_reg      <= bz * bz;
            spatial_a_reg <= in_pts.mode;
        end
    end

    // stage B logic: sum pixel terms, mixing in depth terms in spatial mode
    logic signed [SUM_W-1:0] dot_xy, na_xy, nb_xy, dot_s, na_s, nb_s;

    always_comb
    begin
        dot_xy = SUM_W'(ab_x_reg) + SUM_W'(ab_y_reg);
        na_xy  = SUM_W'(aa_x_reg) + SUM_W'(aa_y_reg);
        nb_xy  = SUM_W'(bb_x_reg) + SUM_W'(bb_y_reg);
        if (spatial_a_reg)
        begin
            dot_s = (dot_xy <<< (2 * DEPTH_FRAC_BITS)) + SUM_W'(ab_z_reg);
            na_s  = (na_xy <<< (2 * DEPTH_FRAC_BITS)) + SUM_W'(aa_z_reg);
            nb_s  = (nb_xy <<< (2 * DEPTH_FRAC_BITS)) + SUM_W'(bb_z_reg);
        end
        else
        begin
            dot_s = dot_xy;
            na_s  = na_xy;
            nb_s  = nb_xy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_b && va_reg)
        begin
            mag_reg     <= dot_s[SUM_W-1] ? MAG_W'(-dot_s) : dot_s[MAG_W-1:0];
            na_reg      <= na_s[MAG_W-1:0];
            nb_reg      <= nb_s[MAG_W-1:0];
            neg_b_reg   <= dot_s[SUM_W-1];
            degen_b_reg <= (na_s == '0) || (nb_s == '0);
        end
    end

    // stage C: half-width partial products
    logic [HALF_HI-1:0] m_hi, a_hi, b_hi;
    logic [HALF_LO-1:0] m_lo, a_lo, b_lo;

    assign m_hi = mag_reg[MAG_W-1:HALF_LO];
    assign m_lo = mag_reg[HALF_LO-1:0];
    assign a_hi = na_reg[MAG_W-1:HALF_LO];
    assign a_lo = na_reg[HALF_LO-1:0];
    assign b_hi = nb_reg[MAG_W-1:HALF_LO];
    assign b_lo = nb_reg[HALF_LO-1:0];

    always_ff @(posedge clk)
    begin
        if (adv_c && vb_reg)
        begin
            mm_hh_reg   <= m_hi * m_hi;
            mm_hl_reg   <= m_hi * m_lo;
            mm_ll_reg   <= m_lo * m_lo;
            nn_hh_reg   <= a_hi * b_hi;
            nn_hl_reg   <= a_hi * b_lo;
            nn_lh_reg   <= a_lo * b_hi;
            nn_ll_reg   <= a_lo * b_lo;
            neg_c_reg   <= neg_b_reg;
            degen_c_reg <= degen_b_reg;
        end
    end

    // stage D: assemble products, seed the root recurrence
    logic [PROD_W-1:0] mm, nn;
    vac_root_t         seed;

    always_comb
    begin
        mm = (PROD_W'(mm_hh_reg) << (2 * HALF_LO)) + (PROD_W'(mm_hl_reg) << (HALF_LO + 1))
           + PROD_W'(mm_ll_reg);
        nn = (PROD_W'(nn_hh_reg) << (2 * HALF_LO))
           + ((PROD_W'(nn_hl_reg) + PROD_W'(nn_lh_reg)) << HALF_LO) + PROD_W'(nn_ll_reg);
        seed.rem   = WW'(mm) << (2 * COS_FRAC_BITS + 2);
        seed.psh   = '0;
        seed.lsh   = WW'(nn) << (2 * (TB - 1));
        seed.t     = '0;
        seed.neg   = neg_c_reg;
        seed.degen = degen_c_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv_d && vc_reg)
        begin
            root_reg <= seed;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/vac_cell.sv
// Root cell: decides one bit of t, the largest t with t^2 * L <= R.
`default_nettype none
module vac_cell
    import vac_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire vac_root_t in_root,
    output logic           in_ready,
    output logic           out_valid,
    output vac_root_t      out_root,
    input  wire logic      out_ready
);

    logic      valid_reg;
    vac_root_t root_reg;
    vac_root_t root_next;
    logic [WW:0] trial;
    logic [WW:0] psum;
    logic        take;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_root  = root_reg;

    // trial increment (2*t*2^i + 2^2i) * L against the remainder
    always_comb
    begin
        trial = {1'b0, in_root.psh} + {1'b0, in_root.lsh};
        take  = trial <= {1'b0, in_root.rem};
        psum  = {1'b0, in_root.psh} + (take ? {in_root.lsh, 1'b0} : '0);
        root_next       = in_root;
        root_next.rem   = take ? (in_root.rem - trial[WW-1:0]) : in_root.rem;
        root_next.psh   = psum[WW:1];
        root_next.lsh   = in_root.lsh >> 2;
        root_next.t     = {in_root.t[TB-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            root_reg <= root_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/vector_angle_cosine.sv
// Top level: cosine of the angle at a vertex between two arms.
//
// Channel pts carries one point triple per beat (vertex p0, arm ends p1, p2)
// and mode (0 planar x,y; 1 spatial x,y,z). Channel res returns one beat per
// input beat, in order: cosine as signed Q1.14, rounded to nearest with ties
// away from zero and clamped to plus or minus one, and degenerate, set with
// cosine 0 when either arm has zero length.
// From input beat to result valid a beat passes four front stages
// (differences and products, sums, split wide products, root seed), one root
// cell per result bit (16 cells), and the output register.
// Throughput is one beat per cycle while res is ready; every stage and
// cell is a register with its own valid bit, so bubbles close up when res
// stalls and pts.ready only drops once every stage holds a beat.
// Reset clears all valid bits; no item is in flight afterwards and the block
// accepts a beat in the first cycle after reset is released.
// A stalled result holds on res until res.ready is seen.
`default_nettype none
module vector_angle_cosine
    import vac_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    vac_pts_if.sink   pts,
    vac_res_if.source res
);

    vac_pts_t  pts_in;
    logic      front_valid, front_ready;
    vac_root_t front_root;

    logic      cell_valid [TB+1];
    logic      cell_ready [TB+1];
    vac_root_t cell_root  [TB+1];

    logic                    out_valid_reg;
    logic signed [COS_W-1:0] cosine_reg;
    logic                    degen_reg;
    logic                    out_load;

    always_comb
    begin
        pts_in.mode = pts.mode;
        pts_in.p0_x = pts.p0_x;
        pts_in.p0_y = pts.p0_y;
        pts_in.p0_z = pts.p0_z;
        pts_in.p1_x = pts.p1_x;
        pts_in.p1_y = pts.p1_y;
        pts_in.p1_z = pts.p1_z;
        pts_in.p2_x = pts.p2_x;
        pts_in.p2_y = pts.p2_y;
        pts_in.p2_z = pts.p2_z;
    end

    vac_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pts.valid),
        .in_pts    (pts_in),
        .in_ready  (pts.ready),
        .out_valid (front_valid),
        .out_root  (front_root),
        .out_ready (front_ready)
    );

    assign cell_valid[0] = front_valid;
    assign cell_root[0]  = front_root;
    assign front_ready   = cell_ready[0];

    // one cell per bit of t, most significant first
    for (genvar i = 0; i < TB; i++)
    begin : g_cell
        vac_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[i]),
            .in_root   (cell_root[i]),
            .in_ready  (cell_ready[i]),
            .out_valid (cell_valid[i+1]),
            .out_root  (cell_root[i+1]),
            .out_ready (cell_ready[i+1])
        );
    end

    assign out_load       = !out_valid_reg || res.ready;
    assign cell_ready[TB] = out_load;

    // count of odd t not above the root, clamped to one, then signed
    logic [TB-1:0]  t_fin;
    logic [TB:0]    half_cnt;
    logic [TB-1:0]  mag;
    logic [COS_W-1:0] cos_val;

    always_comb
    begin
        t_fin    = cell_root[TB].t;
        half_cnt = ({1'b0, t_fin} + (TB+1)'(1)) >> 1;
        mag      = (half_cnt > {1'b0, ONE}) ? ONE : half_cnt[TB-1:0];
        if (cell_root[TB].degen)
        begin
            cos_val = '0;
        end
        else if (cell_root[TB].neg)
        begin
            cos_val = COS_W'(-mag);
        end
        else
        begin
            cos_val = COS_W'(mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= cell_valid[TB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && cell_valid[TB])
        begin
            cosine_reg <= $signed(cos_val);
            degen_reg  <= cell_root[TB].degen;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.cosine     = cosine_reg;
    assign res.degenerate = degen_reg;

endmodule
`default_nettype wire
